// ----- hdl/xoodoo_permutation_assert.svh -----
// Assertion macros for the Xoodoo permutation block.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef XOODOO_PERMUTATION_ASSERT_SVH
`define XOODOO_PERMUTATION_ASSERT_SVH

// Antecedent and consequent in the same cycle
`define XOO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent
`define XOO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/xoo_pkg.sv -----
// Shared types, constants and helper functions for the Xoodoo permutation.
// No dependencies.
package xoo_pkg;

  localparam int unsigned NumWords  = 12;
  localparam int unsigned MaxRounds = 12;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CntW      = 4;
  localparam int unsigned PaddrW    = 4;

  // Register word index on the APB port
  localparam logic [1:0] RegRoundCount = 2'd0;

  typedef logic [NumWords-1:0][WordW-1:0] state_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_EMIT
  } xoo_state_e;

  localparam logic [CntW-1:0] LastWord  = CntW'(NumWords - 1);
  localparam logic [CntW-1:0] MaxRndCnt = CntW'(MaxRounds);

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] round_const(input logic [CntW-1:0] idx);
    logic [WordW-1:0] rc;
    case (idx)
      4'd0:    rc = 32'h0000_0058;
      4'd1:    rc = 32'h0000_0038;
      4'd2:    rc = 32'h0000_03C0;
      4'd3:    rc = 32'h0000_00D0;
      4'd4:    rc = 32'h0000_0120;
      4'd5:    rc = 32'h0000_0014;
      4'd6:    rc = 32'h0000_0060;
      4'd7:    rc = 32'h0000_002C;
      4'd8:    rc = 32'h0000_0380;
      4'd9:    rc = 32'h0000_00F0;
      4'd10:   rc = 32'h0000_01A0;
      4'd11:   rc = 32'h0000_0012;
      default: rc = '0;
    endcase
    return rc;
  endfunction

endpackage

// ----- hdl/xoo_if.sv -----
// Valid/ready stream interfaces for the Xoodoo permutation.
// Depends on xoo_pkg.
interface xoo_in_if;
  logic                     valid;
  logic                     ready;
  logic [xoo_pkg::WordW-1:0] state_word;

  modport source (output valid, output state_word, input ready);
  modport sink   (input valid, input state_word, output ready);
endinterface

interface xoo_out_if;
  logic                      valid;
  logic                      ready;
  logic [xoo_pkg::WordW-1:0] out_word;
  logic [xoo_pkg::CntW-1:0]  out_index;
  logic                      last_word;

  modport source (output valid, output out_word, output out_index, output last_word,
                  input ready);
  modport sink   (input valid, input out_word, input out_index, input last_word,
                  output ready);
endinterface

// ----- hdl/xoodoo_permutation.sv -----
// Xoodoo-384 permutation block.
// Input stream: twelve 32-bit state_word transfers, position plane*4 + sheet.
// After the twelfth the block runs round_count rounds on one shared round unit,
// one round per clock, then streams the twelve words out with out_index and
// last_word set on the twelfth.
// Phases: twelve loads, n rounds (n = round_count, saturated at 12, 0 passes
// the state through), twelve emits; no new word is taken until the last word
// of a block is out. The single round unit sets the middle phase.
// in_if.ready is high only while loading; out_if.valid only while emitting.
// A receiver stall holds the current output word and delays the rest.
// Reset (rst_ni, async, active low) returns to loading with count zero and
// round_count = 12. The state store is not reset.
// APB: register round_count at byte address 0, written when psel, penable,
// pwrite are high; pready is always high. The user must write only while the
// block is idle; the block itself does not enforce this.
// Depends on xoo_pkg, xoo_if, xoo_round and the assertion macro header.
`include "xoodoo_permutation_assert.svh"

module xoodoo_permutation #(
  parameter int unsigned PADDR_W = xoo_pkg::PaddrW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  xoo_in_if.sink             in_if,
  xoo_out_if.source          out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import xoo_pkg::*;

  xoo_state_e      state_q, state_d;
  state_t          store_q;
  state_t          round_out;
  logic [CntW-1:0] round_count_q;
  logic [CntW-1:0] load_cnt_q;
  logic [CntW-1:0] emit_idx_q;
  logic [CntW-1:0] rc_idx_q;
  logic [CntW-1:0] rounds_eff;
  logic            in_xfer;
  logic            out_xfer;
  logic            cfg_wr;
  logic            reg_hit;

  // APB register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(RegRoundCount));
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? {28'd0, round_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= MaxRndCnt;
    end else if (cfg_wr) begin
      round_count_q <= pwdata[CntW-1:0];
    end
  end

  assign rounds_eff = (round_count_q > MaxRndCnt) ? MaxRndCnt : round_count_q;
  assign in_xfer    = in_if.valid && in_if.ready;
  assign out_xfer   = out_if.valid && out_if.ready;

  xoo_round u_round (
    .state_i  (store_q),
    .rc_idx_i (rc_idx_q),
    .state_o  (round_out)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_xfer && load_cnt_q == LastWord) begin
          state_d = (rounds_eff == '0) ? ST_EMIT : ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rc_idx_q == LastWord) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer && emit_idx_q == LastWord) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    in_if.ready      = 1'b0;
    out_if.valid     = 1'b0;
    case (state_q)
      ST_LOAD:  in_if.ready  = 1'b1;
      ST_EMIT:  out_if.valid = 1'b1;
      default: begin
        in_if.ready  = 1'b0;
        out_if.valid = 1'b0;
      end
    endcase
    out_if.out_word  = store_q[emit_idx_q];
    out_if.out_index = emit_idx_q;
    out_if.last_word = (emit_idx_q == LastWord);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      emit_idx_q <= '0;
      rc_idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        load_cnt_q <= (load_cnt_q == LastWord) ? '0 : load_cnt_q + 1'b1;
        // first round constant is the one n places before the end of the list
        if (load_cnt_q == LastWord) rc_idx_q <= MaxRndCnt - rounds_eff;
      end
      if (state_q == ST_ROUND) rc_idx_q <= rc_idx_q + 1'b1;
      if (out_xfer) begin
        emit_idx_q <= (emit_idx_q == LastWord) ? '0 : emit_idx_q + 1'b1;
      end
    end
  end

  // State store, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      store_q[load_cnt_q] <= in_if.state_word;
    end else if (state_q == ST_ROUND) begin
      store_q <= round_out;
    end
  end

  `XOO_ASSERT_SAME(a_no_overlap, out_if.valid, !in_if.ready, "load and emit overlap")
  `XOO_ASSERT_NEXT(a_last_to_load, out_xfer && out_if.last_word,
                   in_if.ready && load_cnt_q == '0 && emit_idx_q == '0,
                   "no return to loading after last word")
  `XOO_ASSERT_NEXT(a_start_rounds, in_xfer && load_cnt_q == LastWord && rounds_eff != '0,
                   state_q == ST_ROUND, "rounds not started after twelfth word")
  `XOO_ASSERT_SAME(a_rc_range, state_q == ST_ROUND, rc_idx_q <= LastWord,
                   "round constant index out of range")

endmodule

// ----- hdl/xoo_round.sv -----
// One Xoodoo round: theta, rho-west, iota, chi, rho-east over the 384-bit state.
// Depends on xoo_pkg. Purely combinational, reused once per round by the sequencer.
module xoo_round (
  input  xoo_pkg::state_t              state_i,
  input  logic [xoo_pkg::CntW-1:0]     rc_idx_i,
  output xoo_pkg::state_t              state_o
);
  import xoo_pkg::*;

  logic [3:0][WordW-1:0] p;
  logic [3:0][WordW-1:0] e;
  state_t                th;
  state_t                rw;
  state_t                ch;

  always_comb begin
    // theta: column parity, shifted by one sheet and folded
    for (int x = 0; x < 4; x++) begin
      p[x] = state_i[x] ^ state_i[4+x] ^ state_i[8+x];
    end
    for (int x = 0; x < 4; x++) begin
      e[x] = rotl(p[(x+3)%4], 5) ^ rotl(p[(x+3)%4], 14);
    end
    for (int i = 0; i < 12; i++) begin
      th[i] = state_i[i] ^ e[i%4];
    end

    // rho-west
    for (int x = 0; x < 4; x++) begin
      rw[x]   = th[x];
      rw[4+x] = th[4+((x+3)%4)];
      rw[8+x] = rotl(th[8+x], 11);
    end

    // iota
    rw[0] = rw[0] ^ round_const(rc_idx_i);

    // chi
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 4; x++) begin
        ch[4*y+x] = rw[4*y+x] ^ (~rw[4*((y+1)%3)+x] & rw[4*((y+2)%3)+x]);
      end
    end

    // rho-east
    for (int x = 0; x < 4; x++) begin
      state_o[x]   = ch[x];
      state_o[4+x] = rotl(ch[4+x], 1);
      state_o[8+x] = rotl(ch[8+((x+2)%4)], 8);
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for xoodoo_permutation: twelve-word blocks are streamed in and the
// permuted words are checked against a local Xoodoo predictor for many round counts.
// Depends on xoo_pkg, xoo_if and the xoodoo_permutation RTL.
module testbench;
  import xoo_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic [CntW-1:0]  index;
    logic             last;
  } perm_word_t;

  localparam logic [1:0] RegNone = 2'd1;  // no register behind these indexes
  localparam logic [1:0] RegTop  = 2'd3;
  localparam int unsigned HoldCycles = 300;
  localparam logic [WordW-1:0] ROUND_CONSTS [MaxRounds] = '{
    32'h058, 32'h038, 32'h3C0, 32'h0D0, 32'h120, 32'h014,
    32'h060, 32'h02C, 32'h380, 32'h0F0, 32'h1A0, 32'h012
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  xoo_in_if  word_in ();
  xoo_out_if word_out ();

  logic              psel, penable, pwrite, pready;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata, prdata;

  xoodoo_permutation DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (word_in),
    .out_if  (word_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic [WordW-1:0] lanes [NumWords];
  int unsigned      fill_count = 0;
  logic [CntW-1:0]  rounds_cfg = CntW'(MaxRounds);

  logic [WordW-1:0] pending_words [$];
  perm_word_t       permuted_words [$];

  int unsigned gap_pct = 12;
  int unsigned stall_pct = 12;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  int unsigned errors = 0;
  int unsigned words_loaded = 0;
  int unsigned words_checked = 0;
  int unsigned settings_used = 0;

  function automatic logic [WordW-1:0] rol(input logic [WordW-1:0] v, input int unsigned n);
    if (n == 0) return v;
    return (v << n) | (v >> (WordW - n));
  endfunction

  function automatic void perm_round(input logic [WordW-1:0] rc);
    logic [WordW-1:0] p [4];
    logic [WordW-1:0] e [4];
    logic [WordW-1:0] t [NumWords];
    for (int x = 0; x < 4; x++) p[x] = lanes[x] ^ lanes[x+4] ^ lanes[x+8];
    for (int x = 0; x < 4; x++) e[x] = rol(p[(x+3)%4], 5) ^ rol(p[(x+3)%4], 14);
    for (int x = 0; x < 4; x++)
      for (int y = 0; y < 3; y++) lanes[x+4*y] ^= e[x];
    // rho-west: plane 1 shifts one sheet, plane 2 rotates by 11
    for (int x = 0; x < 4; x++) begin
      t[x+4] = lanes[((x+3)%4)+4];
      t[x+8] = rol(lanes[x+8], 11);
    end
    for (int x = 0; x < 4; x++) begin
      lanes[x+4] = t[x+4];
      lanes[x+8] = t[x+8];
    end
    lanes[0] ^= rc;
    for (int x = 0; x < 4; x++)
      for (int y = 0; y < 3; y++)
        t[x+4*y] = lanes[x+4*y] ^ (~lanes[x+4*((y+1)%3)] & lanes[x+4*((y+2)%3)]);
    for (int i = 0; i < NumWords; i++) lanes[i] = t[i];
    // rho-east
    for (int x = 0; x < 4; x++) begin
      t[x+4] = rol(lanes[x+4], 1);
      t[x+8] = rol(lanes[((x+2)%4)+8], 8);
    end
    for (int x = 0; x < 4; x++) begin
      lanes[x+4] = t[x+4];
      lanes[x+8] = t[x+8];
    end
  endfunction

  // Store one word; the twelfth runs the permutation and queues the twelve results
  function automatic void load_lane(input logic [WordW-1:0] w);
    int unsigned nr;
    perm_word_t  res;
    lanes[fill_count] = w;
    fill_count++;
    words_loaded++;
    if (fill_count == NumWords) begin
      nr = (rounds_cfg > MaxRounds) ? MaxRounds : rounds_cfg;
      for (int i = MaxRounds - nr; i < MaxRounds; i++) perm_round(ROUND_CONSTS[i]);
      for (int i = 0; i < NumWords; i++) begin
        res.value = lanes[i];
        res.index = CntW'(i);
        res.last  = (i == NumWords - 1);
        permuted_words.push_back(res);
      end
      fill_count = 0;
    end
  endfunction

  function automatic logic [WordW-1:0] random_lane();
    case ($urandom_range(7))
      0:       return WordW'(1) << $urandom_range(WordW - 1);
      1:       return ~(WordW'(1) << $urandom_range(WordW - 1));
      default: return $urandom();
    endcase
  endfunction

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_in.valid <= 1'b0;
    end else begin
      if (word_in.valid && word_in.ready) load_lane(word_in.state_word);
      if (!word_in.valid || word_in.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
          word_in.valid      <= 1'b1;
          word_in.state_word <= pending_words.pop_front();
        end else begin
          word_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    perm_word_t want;
    if (!rst_ni) begin
      word_out.ready <= 1'b0;
    end else begin
      if (word_out.valid && word_out.ready) begin
        if (permuted_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word %h index %0d last %b", $realtime,
                   word_out.out_word, word_out.out_index, word_out.last_word);
        end else begin
          want = permuted_words.pop_front();
          words_checked++;
          if (word_out.out_word !== want.value || word_out.out_index !== want.index ||
              word_out.last_word !== want.last) begin
            errors++;
            $display("%0t: mismatch expected word %h index %0d last %b, got word %h index %0d last %b",
                     $realtime, want.value, want.index, want.last,
                     word_out.out_word, word_out.out_index, word_out.last_word);
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served    <= hold_requests;
        hold_left      <= HoldCycles;
        word_out.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left      <= hold_left - 1;
        word_out.ready <= 1'b0;
      end else begin
        word_out.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_rounds_reg();
    logic [31:0] rd;
    apb_access(RegRoundCount, 1'b0, 32'h0, rd);
    if (rd[CntW-1:0] !== rounds_cfg) begin
      errors++;
      $display("%0t: round_count readback expected %0d, got %0d", $realtime,
               rounds_cfg, rd[CntW-1:0]);
    end
  endtask

  task automatic set_rounds(input logic [CntW-1:0] nr);
    logic [31:0] rd;
    apb_access(RegRoundCount, 1'b1, 32'(nr), rd);
    rounds_cfg = nr;
    settings_used++;
    check_rounds_reg();
  endtask

  // Wait until every queued word is taken and every permuted word has come back
  task automatic drain();
    while (pending_words.size() != 0 || word_in.valid || permuted_words.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_blocks(input logic [CntW-1:0] nr, input int blocks);
    set_rounds(nr);
    for (int i = 0; i < blocks * NumWords; i++) pending_words.push_back(random_lane());
    drain();
  endtask

  initial begin
    logic [31:0] rd;
    word_in.valid      = 1'b0;
    word_in.state_word = '0;
    word_out.ready     = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of twelve rounds, all-zero and all-one words
    check_rounds_reg();
    for (int i = 0; i < NumWords; i++) pending_words.push_back(i < 6 ? '0 : '1);
    drain();

    // zero rounds pass the state through; writes to unused indexes change nothing
    set_rounds('0);
    apb_access(RegNone, 1'b1, 32'h5, rd);
    apb_access(RegTop, 1'b1, 32'hF, rd);
    check_rounds_reg();
    for (int i = 0; i < NumWords; i++)
      pending_words.push_back((i % 2) ? 32'h5555_5555 ^ (32'h1 << i) : 32'hAAAA_AAAA);
    drain();

    // random part; counts above twelve saturate
    run_blocks(4'd1, 2);
    run_blocks(4'd15, 2);
    run_blocks(4'd7, 2);

    // long stretch with no idling on either side
    gap_pct = 0;
    stall_pct = 0;
    run_blocks(4'd12, 3);
    gap_pct = 12;
    stall_pct = 12;

    // receiver holds off while the sender keeps offering
    set_rounds(4'd13);
    hold_requests++;
    for (int i = 0; i < 3 * NumWords; i++) pending_words.push_back(random_lane());
    drain();

    run_blocks(4'd2, 2);
    run_blocks(4'd14, 2);
    run_blocks(CntW'($urandom_range(MaxRounds, 1)), 2);
    run_blocks(4'd11, 2);
    run_blocks(4'd0, 1);
    run_blocks(4'd6, 2);
    run_blocks(4'd3, 2);

    repeat (40) @(posedge clk_i);
    $display("summary: %0d words loaded, %0d permuted words checked", words_loaded,
             words_checked);
    $display("summary: %0d round-count settings incl. zero, saturation and a long output stall",
             settings_used);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
